// ===== design/boc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the Bruhat order comparator.
package boc_pkg;

	localparam int MAX_ELEMENTS_DEF = 8;
	localparam int INDEX_W = 16;
	localparam int SIZE_W = 4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// Pipeline control shared by every stage.
	typedef struct packed {
		logic adv;
		logic [SIZE_W-1:0] n;
	} ctl_t;

endpackage

// ===== design/boc_decoder.sv =====
`timescale 1ns / 1ps
// Pipelined Lehmer index to permutation decoder.
module boc_decoder #(
	parameter int MAX_ELEMENTS = boc_pkg::MAX_ELEMENTS_DEF
) (
	input logic clk,
	input boc_pkg::ctl_t ctl,
	input logic [boc_pkg::INDEX_W-1:0] index,
	output logic [MAX_ELEMENTS-1:0][$clog2(MAX_ELEMENTS)-1:0] seq
);

	localparam int VW = $clog2(MAX_ELEMENTS);
	localparam int ND = MAX_ELEMENTS - 2;
	localparam int IW = boc_pkg::INDEX_W;
	localparam int SW = boc_pkg::SIZE_W;

	typedef logic [MAX_ELEMENTS-1:0][VW-1:0] vec_t;

	logic [IW-1:0] rest_s [0:ND];
	vec_t dig_s [0:ND];
	logic [IW-1:0] d0;

	vec_t pool_s [0:MAX_ELEMENTS];
	logic [SW-1:0] cnt_s [0:MAX_ELEMENTS];
	vec_t seq_s [0:MAX_ELEMENTS];
	vec_t dgp_s [0:MAX_ELEMENTS];

	assign rest_s[0] = index;
	assign dig_s[0] = '0;

	// Digits come out least significant first: stage s divides by s + 1.
	// The remainder is the digit for position n - 1 - s.
	for (genvar s = 1; s <= ND; s++) begin : g_div
		localparam int D = s + 1;
		localparam int RECIP = (1 << IW) / D;

		logic [2*IW-1:0] prod;
		logic [IW-1:0] q0, r0, q_c, r_c;
		logic act;
		logic [SW-1:0] pos;
		vec_t dig_n;

		always_comb begin
			prod = {{IW{1'b0}}, rest_s[s-1]} * (2*IW)'(RECIP);
			q0 = prod[2*IW-1:IW];
			r0 = rest_s[s-1] - IW'(q0 * IW'(D));
			// The truncated reciprocal can leave the quotient one short.
			if (r0 >= IW'(D)) begin
				q_c = q0 + IW'(1);
				r_c = r0 - IW'(D);
			end else begin
				q_c = q0;
				r_c = r0;
			end
			act = SW'(s + 2) <= ctl.n;
			pos = ctl.n - SW'(s + 1);
			dig_n = dig_s[s-1];
			for (int p = 1; p < MAX_ELEMENTS - 1; p++) begin
				if (act && pos == SW'(p)) begin
					dig_n[p] = VW'(r_c);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rest_s[s] <= act ? q_c : rest_s[s-1];
				dig_s[s] <= dig_n;
			end
		end
	end

	// The leading digit is whatever is left; with one element there is no digit.
	assign d0 = (ctl.n == SW'(1)) ? '0 : rest_s[ND];

	for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_ident
		assign pool_s[0][k] = VW'(k);
	end
	assign cnt_s[0] = ctl.n;
	assign seq_s[0] = '0;
	assign dgp_s[0] = dig_s[ND];

	// One position per stage: pick the digit-th remaining value and close the gap.
	for (genvar j = 0; j < MAX_ELEMENTS; j++) begin : g_perm
		logic [IW-1:0] dcur;
		logic in_rng, take;
		logic [VW-1:0] pick;
		vec_t pool_n, seq_n;

		always_comb begin
			dcur = (j == 0) ? d0 : IW'(dgp_s[j][j]);
			in_rng = SW'(j) < ctl.n;
			take = in_rng && (dcur < IW'(cnt_s[j]));
			pick = '0;
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				if (dcur == IW'(k)) begin
					pick = pool_s[j][k];
				end
			end
			pool_n = pool_s[j];
			for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
				if (take && IW'(k) >= dcur) begin
					pool_n[k] = pool_s[j][k+1];
				end
			end
			seq_n = seq_s[j];
			// An out-of-range digit yields element zero and leaves the pool alone.
			seq_n[j] = take ? pick : '0;
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				pool_s[j+1] <= pool_n;
				cnt_s[j+1] <= take ? (cnt_s[j] - SW'(1)) : cnt_s[j];
				seq_s[j+1] <= seq_n;
				dgp_s[j+1] <= dgp_s[j];
			end
		end
	end

	assign seq = seq_s[MAX_ELEMENTS];

endmodule

// ===== design/boc_prefix_lane.sv =====
`timescale 1ns / 1ps
// Tableau check for one prefix length over all value thresholds.
module boc_prefix_lane #(
	parameter int MAX_ELEMENTS = boc_pkg::MAX_ELEMENTS_DEF,
	parameter int PREFIX = 0
) (
	input logic clk,
	input boc_pkg::ctl_t ctl,
	input logic [MAX_ELEMENTS-1:0][$clog2(MAX_ELEMENTS)-1:0] lo_seq,
	input logic [MAX_ELEMENTS-1:0][$clog2(MAX_ELEMENTS)-1:0] up_seq,
	output logic viol
);

	localparam int VW = $clog2(MAX_ELEMENTS);
	localparam int SW = boc_pkg::SIZE_W;

	logic [SW-1:0] ca, cb;
	logic hit;
	logic viol_s1;

	always_comb begin
		hit = 1'b0;
		for (int t = 0; t < MAX_ELEMENTS; t++) begin
			ca = '0;
			cb = '0;
			for (int k = 0; k <= PREFIX; k++) begin
				ca = ca + SW'(lo_seq[k] >= VW'(t));
				cb = cb + SW'(up_seq[k] >= VW'(t));
			end
			if (ca > cb && SW'(t) < ctl.n) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			viol_s1 <= hit && (SW'(PREFIX) < ctl.n);
		end
	end

	assign viol = viol_s1;

endmodule

// ===== design/bruhat_order_compare.sv =====
`timescale 1ns / 1ps
// Top level of the Bruhat order comparator for permutations of up to MAX_ELEMENTS elements.

// Takes one request per cycle unless stalled and returns one result per request,
// in order. Each request goes through 2*MAX_ELEMENTS-2 decode stages (one
// division by a small constant per factorial digit, then one stage per
// permutation position), one stage where MAX_ELEMENTS prefix lanes test all
// thresholds, and the output register. A stall on the output holds the whole
// pipeline. The element count is saturated to 1..MAX_ELEMENTS when written.
module bruhat_order_compare #(
	parameter int MAX_ELEMENTS = boc_pkg::MAX_ELEMENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [boc_pkg::SIZE_W-1:0] cfg_wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic [boc_pkg::INDEX_W-1:0] lower_index,
	input logic [boc_pkg::INDEX_W-1:0] upper_index,
	output logic out_valid,
	input logic out_stall,
	output logic is_below
);

	localparam int VW = $clog2(MAX_ELEMENTS);
	localparam int SW = boc_pkg::SIZE_W;
	localparam int LT = 2 * MAX_ELEMENTS - 1;
	localparam logic [SW-1:0] N_MAX = SW'(MAX_ELEMENTS);
	localparam logic [SW-1:0] N_RST =
		(boc_pkg::SIZE_RESET > N_MAX) ? N_MAX : boc_pkg::SIZE_RESET;

	logic [SW-1:0] n_q;
	logic adv;
	logic [LT-1:0] vld_s;
	logic out_valid_q;
	logic is_below_q;
	boc_pkg::ctl_t ctl;
	logic [MAX_ELEMENTS-1:0][VW-1:0] lo_seq, up_seq;
	logic [MAX_ELEMENTS-1:0] viol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= N_RST;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data > N_MAX) begin
				n_q <= N_MAX;
			end else if (cfg_wr_data == '0) begin
				n_q <= SW'(1);
			end else begin
				n_q <= cfg_wr_data;
			end
		end
	end

	// Everything moves together unless the output holds a result that is stalled.
	assign adv = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	assign ctl.adv = adv;
	assign ctl.n = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[LT-2:0], in_valid};
			out_valid_q <= vld_s[LT-1];
		end
	end

	boc_decoder #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dec_lo (
		.clk(clk),
		.ctl(ctl),
		.index(lower_index),
		.seq(lo_seq)
	);

	boc_decoder #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dec_up (
		.clk(clk),
		.ctl(ctl),
		.index(upper_index),
		.seq(up_seq)
	);

	for (genvar p = 0; p < MAX_ELEMENTS; p++) begin : g_lane
		boc_prefix_lane #(.MAX_ELEMENTS(MAX_ELEMENTS), .PREFIX(p)) u_lane (
			.clk(clk),
			.ctl(ctl),
			.lo_seq(lo_seq),
			.up_seq(up_seq),
			.viol(viol[p])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_below_q <= ~|viol;
		end
	end

	assign out_valid = out_valid_q;
	assign is_below = is_below_q;

`ifndef SYNTHESIS
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) && (n_q <= N_MAX))
		else $error("element count left the range 1 to MAX_ELEMENTS");

	a_single_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (n_q == SW'(1)) |-> is_below_q)
		else $error("single-element group gave a result other than below");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s[LT-1]))
		else $error("result appeared without a request at the end of the pipeline");
`endif

endmodule
